/* src/ibw_pkg.sv */
// Package for the inverse bilinear weights core.
// Holds register map, opcodes, microcode ROM, state types and saturation helper.
// No dependencies.
package ibw_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_ITER_WIDTH  = 8;
    localparam int DATA_W          = 32;
    localparam int ACC_W           = 52;
    localparam int PROD_W          = 64;
    localparam int NUM_IN          = 10;
    localparam int NUM_REGS        = 26;
    localparam int ADDR_W          = 5;
    localparam int PC_W            = 7;
    localparam int LOAD_LAST       = 11;
    localparam int ONE_Q16         = 65536;
    localparam int HALF_Q16        = 32768;
    localparam int DIV_DVD_W       = 48;
    localparam int FRAC_BITS       = 16;

    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd1;
    localparam logic [7:0]  RST_MAX_ITER  = 8'd50;
    localparam logic [15:0] RST_TOLERANCE = 16'd1;

    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_LIMIT     = 2'd1;
    localparam logic [1:0] STAT_DEGEN     = 2'd2;

    typedef enum logic [ADDR_W-1:0] {
        R_PX0, R_PX1, R_PX2, R_PX3, R_PY0, R_PY1, R_PY2, R_PY3,
        R_TX, R_TY, R_PHI, R_CHI, R_MP, R_MC,
        R_W0, R_W1, R_W2, R_W3,
        R_A00, R_A01, R_A10, R_A11, R_B0, R_B1, R_X0, R_X1
    } t_reg;

    typedef enum logic [4:0] {
        OP_CLR, OP_LD, OP_ADD, OP_SUB, OP_K1SUB, OP_SAT, OP_RSUBSAT,
        OP_MAC16, OP_MSC16, OP_MAC30, OP_MULW, OP_ST, OP_STR,
        OP_MOVS, OP_LDS, OP_CHK, OP_DIV
    } t_op;

    typedef struct packed {
        t_op  op;
        t_reg ra;
        t_reg rb;
        t_reg rd;
        logic last;
    } t_instr;

    typedef enum logic [2:0] {
        ST_LOAD, ST_RD, ST_MUL, ST_EXE, ST_DIV, ST_NEXT, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SEG_WGT, SEG_ITER, SEG_GSI, SEG_SWP, SEG_UPD
    } t_seg;

    localparam logic [PC_W-1:0] PC_WGT  = 7'd0;
    localparam logic [PC_W-1:0] PC_ITER = 7'd12;
    localparam logic [PC_W-1:0] PC_GSI  = 7'd52;
    localparam logic [PC_W-1:0] PC_SWP  = 7'd55;
    localparam logic [PC_W-1:0] PC_UPD  = 7'd73;

    typedef struct packed {
        logic       load_we;
        logic [3:0] load_idx;
        logic       exe_en;
        logic       div_wb;
        logic       ok_init;
        logic       out_load;
        logic [1:0] out_status;
        logic [7:0] out_iter;
        t_instr     ins;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic conv;
        logic sweep_ok;
        logic div_done;
        logic out_valid;
    } t_sts;

    function automatic t_instr mk(t_op op, t_reg ra, t_reg rb, t_reg rd, logic last);
        t_instr r;
        r.op = op; r.ra = ra; r.rb = rb; r.rd = rd; r.last = last;
        return r;
    endfunction

    // clamp a 64-bit value to w signed bits, sign-extended to 32
    function automatic logic signed [DATA_W-1:0] sat64(logic signed [PROD_W-1:0] v, int w);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (w - 1));
        if (v > hi) return DATA_W'(hi);
        if (v < lo) return DATA_W'(lo);
        return DATA_W'(v);
    endfunction

    function automatic t_instr ucode(logic [PC_W-1:0] pc);
        t_instr r;
        r = mk(OP_CLR, R_PX0, R_PX0, R_PX0, 1'b1);
        case (pc)
            // weights of current (phi, chi)
            7'd0:  r = mk(OP_K1SUB, R_PHI, R_PX0, R_PX0, 1'b0);
            7'd1:  r = mk(OP_ST,    R_PX0, R_PX0, R_MP,  1'b0);
            7'd2:  r = mk(OP_K1SUB, R_CHI, R_PX0, R_PX0, 1'b0);
            7'd3:  r = mk(OP_ST,    R_PX0, R_PX0, R_MC,  1'b0);
            7'd4:  r = mk(OP_MULW,  R_MP,  R_MC,  R_PX0, 1'b0);
            7'd5:  r = mk(OP_STR,   R_PX0, R_PX0, R_W0,  1'b0);
            7'd6:  r = mk(OP_MULW,  R_PHI, R_MC,  R_PX0, 1'b0);
            7'd7:  r = mk(OP_STR,   R_PX0, R_PX0, R_W1,  1'b0);
            7'd8:  r = mk(OP_MULW,  R_PHI, R_CHI, R_PX0, 1'b0);
            7'd9:  r = mk(OP_STR,   R_PX0, R_PX0, R_W2,  1'b0);
            7'd10: r = mk(OP_MULW,  R_MP,  R_CHI, R_PX0, 1'b0);
            7'd11: r = mk(OP_STR,   R_PX0, R_PX0, R_W3,  1'b1);
            // residuals
            7'd12: r = mk(OP_CLR,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd13: r = mk(OP_MAC30,   R_W0,  R_PX0, R_PX0, 1'b0);
            7'd14: r = mk(OP_MAC30,   R_W1,  R_PX1, R_PX0, 1'b0);
            7'd15: r = mk(OP_MAC30,   R_W2,  R_PX2, R_PX0, 1'b0);
            7'd16: r = mk(OP_MAC30,   R_W3,  R_PX3, R_PX0, 1'b0);
            7'd17: r = mk(OP_SAT,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd18: r = mk(OP_RSUBSAT, R_TX,  R_PX0, R_PX0, 1'b0);
            7'd19: r = mk(OP_ST,      R_PX0, R_PX0, R_B0,  1'b0);
            7'd20: r = mk(OP_CLR,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd21: r = mk(OP_MAC30,   R_W0,  R_PY0, R_PX0, 1'b0);
            7'd22: r = mk(OP_MAC30,   R_W1,  R_PY1, R_PX0, 1'b0);
            7'd23: r = mk(OP_MAC30,   R_W2,  R_PY2, R_PX0, 1'b0);
            7'd24: r = mk(OP_MAC30,   R_W3,  R_PY3, R_PX0, 1'b0);
            7'd25: r = mk(OP_SAT,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd26: r = mk(OP_RSUBSAT, R_TY,  R_PX0, R_PX0, 1'b0);
            7'd27: r = mk(OP_ST,      R_PX0, R_PX0, R_B1,  1'b0);
            // Jacobian
            7'd28: r = mk(OP_CLR,   R_PX0, R_PX0, R_PX0, 1'b0);
            7'd29: r = mk(OP_MAC16, R_MC,  R_PX1, R_PX0, 1'b0);
            7'd30: r = mk(OP_MSC16, R_MC,  R_PX0, R_PX0, 1'b0);
            7'd31: r = mk(OP_MAC16, R_CHI, R_PX2, R_PX0, 1'b0);
            7'd32: r = mk(OP_MSC16, R_CHI, R_PX3, R_PX0, 1'b0);
            7'd33: r = mk(OP_ST,    R_PX0, R_PX0, R_A00, 1'b0);
            7'd34: r = mk(OP_CLR,   R_PX0, R_PX0, R_PX0, 1'b0);
            7'd35: r = mk(OP_MAC16, R_MP,  R_PX3, R_PX0, 1'b0);
            7'd36: r = mk(OP_MSC16, R_MP,  R_PX0, R_PX0, 1'b0);
            7'd37: r = mk(OP_MAC16, R_PHI, R_PX2, R_PX0, 1'b0);
            7'd38: r = mk(OP_MSC16, R_PHI, R_PX1, R_PX0, 1'b0);
            7'd39: r = mk(OP_ST,    R_PX0, R_PX0, R_A01, 1'b0);
            7'd40: r = mk(OP_CLR,   R_PX0, R_PX0, R_PX0, 1'b0);
            7'd41: r = mk(OP_MAC16, R_MC,  R_PY1, R_PX0, 1'b0);
            7'd42: r = mk(OP_MSC16, R_MC,  R_PY0, R_PX0, 1'b0);
            7'd43: r = mk(OP_MAC16, R_CHI, R_PY2, R_PX0, 1'b0);
            7'd44: r = mk(OP_MSC16, R_CHI, R_PY3, R_PX0, 1'b0);
            7'd45: r = mk(OP_ST,    R_PX0, R_PX0, R_A10, 1'b0);
            7'd46: r = mk(OP_CLR,   R_PX0, R_PX0, R_PX0, 1'b0);
            7'd47: r = mk(OP_MAC16, R_MP,  R_PY3, R_PX0, 1'b0);
            7'd48: r = mk(OP_MSC16, R_MP,  R_PY0, R_PX0, 1'b0);
            7'd49: r = mk(OP_MAC16, R_PHI, R_PY2, R_PX0, 1'b0);
            7'd50: r = mk(OP_MSC16, R_PHI, R_PY1, R_PX0, 1'b0);
            7'd51: r = mk(OP_ST,    R_PX0, R_PX0, R_A11, 1'b1);
            // Gauss-Seidel unknowns start at zero
            7'd52: r = mk(OP_CLR, R_PX0, R_PX0, R_PX0, 1'b0);
            7'd53: r = mk(OP_ST,  R_PX0, R_PX0, R_X0,  1'b0);
            7'd54: r = mk(OP_ST,  R_PX0, R_PX0, R_X1,  1'b1);
            // one sweep, row 0 then row 1
            7'd55: r = mk(OP_CLR,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd56: r = mk(OP_MAC16,   R_A01, R_X1,  R_PX0, 1'b0);
            7'd57: r = mk(OP_MOVS,    R_PX0, R_PX0, R_PX0, 1'b0);
            7'd58: r = mk(OP_RSUBSAT, R_B0,  R_PX0, R_PX0, 1'b0);
            7'd59: r = mk(OP_DIV,     R_PX0, R_A00, R_X0,  1'b0);
            7'd60: r = mk(OP_LDS,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd61: r = mk(OP_MAC16,   R_X0,  R_A00, R_PX0, 1'b0);
            7'd62: r = mk(OP_SUB,     R_B0,  R_PX0, R_PX0, 1'b0);
            7'd63: r = mk(OP_CHK,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd64: r = mk(OP_CLR,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd65: r = mk(OP_MAC16,   R_A10, R_X0,  R_PX0, 1'b0);
            7'd66: r = mk(OP_MOVS,    R_PX0, R_PX0, R_PX0, 1'b0);
            7'd67: r = mk(OP_RSUBSAT, R_B1,  R_PX0, R_PX0, 1'b0);
            7'd68: r = mk(OP_DIV,     R_PX0, R_A11, R_X1,  1'b0);
            7'd69: r = mk(OP_LDS,     R_PX0, R_PX0, R_PX0, 1'b0);
            7'd70: r = mk(OP_MAC16,   R_X1,  R_A11, R_PX0, 1'b0);
            7'd71: r = mk(OP_SUB,     R_B1,  R_PX0, R_PX0, 1'b0);
            7'd72: r = mk(OP_CHK,     R_PX0, R_PX0, R_PX0, 1'b1);
            // Newton update
            7'd73: r = mk(OP_LD,  R_PHI, R_PX0, R_PX0, 1'b0);
            7'd74: r = mk(OP_ADD, R_X0,  R_PX0, R_PX0, 1'b0);
            7'd75: r = mk(OP_ST,  R_PX0, R_PX0, R_PHI, 1'b0);
            7'd76: r = mk(OP_LD,  R_CHI, R_PX0, R_PX0, 1'b0);
            7'd77: r = mk(OP_ADD, R_X1,  R_PX0, R_PX0, 1'b0);
            7'd78: r = mk(OP_ST,  R_PX0, R_PX0, R_CHI, 1'b1);
            default: r = mk(OP_CLR, R_PX0, R_PX0, R_PX0, 1'b1);
        endcase
        return r;
    endfunction

endpackage

/* src/ibw_div.sv */
// Sequential signed divider, one quotient bit per cycle, saturating quotient.
// Depends on ibw_pkg.
module ibw_div #(
    parameter int SAT_W = ibw_pkg::DATA_W
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [ibw_pkg::DIV_DVD_W-1:0]  i_dividend,
    input  logic signed [ibw_pkg::DATA_W-1:0]     i_divisor,
    output logic                                  o_done,
    output logic signed [ibw_pkg::DATA_W-1:0]     o_quotient
);
    import ibw_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W + 1);

    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DIV_DVD_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0]    r_dvs;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DATA_W:0]      trial;
    logic                 fits;
    logic signed [DIV_DVD_W:0] q_signed;

    always_comb begin
        trial = {r_rem, r_quo[DIV_DVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? DATA_W'(trial - {1'b0, r_dvs}) : DATA_W'(trial);
        n_quo = {r_quo[DIV_DVD_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DIV_DVD_W-1] ? DIV_DVD_W'(-i_dividend) : DIV_DVD_W'(i_dividend);
            r_dvs <= i_divisor[DATA_W-1] ? DATA_W'(-i_divisor) : DATA_W'(i_divisor);
            r_neg <= i_dividend[DIV_DVD_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // truncation toward zero: divide magnitudes, then apply the sign
    assign q_signed   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_quotient = sat64(PROD_W'(q_signed), SAT_W);
    assign o_done     = r_done;

endmodule

/* src/ibw_datapath.sv */
// Datapath: operand memory, shared multiplier, wide accumulator, divider, result registers.
// Depends on ibw_pkg and ibw_div.
module ibw_datapath #(
    parameter int SAT_W = ibw_pkg::DATA_W
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  ibw_pkg::t_cmd                               i_cmd,
    input  logic [ibw_pkg::NUM_IN-1:0][ibw_pkg::DATA_W-1:0] i_load_data,
    input  logic [15:0]                                 i_tol,
    input  logic                                        i_out_ready,
    output ibw_pkg::t_sts                               o_sts,
    output logic signed [ibw_pkg::DATA_W-1:0]           o_weight [4],
    output logic [1:0]                                  o_status,
    output logic [7:0]                                  o_iter
);
    import ibw_pkg::*;

    logic signed [DATA_W-1:0] mem [NUM_REGS];
    logic signed [DATA_W-1:0] r_rd_a, r_rd_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  r_s;
    logic signed [DATA_W-1:0] r_wsh [4];
    logic                     r_z00, r_z11, r_c0, r_c1, r_ok, r_out_valid;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [ACC_W-1:0]  tol_s, wdata_x;
    logic                     wdata_in_tol, acc_in_tol;
    logic                     div_start, div_done;
    logic signed [DATA_W-1:0] div_q;
    logic signed [DATA_W-1:0] acc_sat;
    t_op                      op;

    assign op      = i_cmd.ins.op;
    assign tol_s   = ACC_W'(i_tol);
    assign acc_sat = sat64(PROD_W'(r_acc), SAT_W);

    ibw_div #(.SAT_W(SAT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_acc[DATA_W-1:0], {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_rd_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign div_start = i_cmd.exe_en && (op == OP_DIV);

    // write port: operand load, accumulator store or divider result
    always_comb begin
        we    = 1'b0;
        waddr = i_cmd.ins.rd;
        wdata = acc_sat;
        if (i_cmd.load_we) begin
            we    = 1'b1;
            waddr = ADDR_W'(i_cmd.load_idx);
            wdata = (i_cmd.load_idx < 4'(NUM_IN)) ? i_load_data[i_cmd.load_idx[3:0]]
                                                  : DATA_W'(HALF_Q16);
        end else if (i_cmd.exe_en && op == OP_ST) begin
            we = 1'b1;
        end else if (i_cmd.exe_en && op == OP_STR) begin
            we    = 1'b1;
            wdata = r_acc[DATA_W-1:0];
        end else if (i_cmd.div_wb) begin
            we    = 1'b1;
            wdata = div_q;
        end
    end

    assign wdata_x      = ACC_W'(wdata);
    assign wdata_in_tol = (wdata_x <= tol_s) && (wdata_x >= -tol_s);
    assign acc_in_tol   = (r_acc <= tol_s) && (r_acc >= -tol_s);

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd_a <= mem[i_cmd.ins.ra];
        r_rd_b <= mem[i_cmd.ins.rb];
        r_prod <= r_rd_a * r_rd_b;
    end

    always_comb begin
        n_acc = r_acc;
        case (op)
            OP_CLR:     n_acc = '0;
            OP_LD:      n_acc = ACC_W'(r_rd_a);
            OP_ADD:     n_acc = r_acc + ACC_W'(r_rd_a);
            OP_SUB:     n_acc = r_acc - ACC_W'(r_rd_a);
            OP_K1SUB:   n_acc = ACC_W'(ONE_Q16) - ACC_W'(r_rd_a);
            OP_SAT:     n_acc = ACC_W'(acc_sat);
            OP_RSUBSAT: n_acc = ACC_W'(sat64(PROD_W'(ACC_W'(r_rd_a) - r_acc), SAT_W));
            OP_MAC16:   n_acc = r_acc + ACC_W'(r_prod >>> 16);
            OP_MSC16:   n_acc = r_acc - ACC_W'(r_prod >>> 16);
            OP_MAC30:   n_acc = r_acc + ACC_W'(r_prod >>> 30);
            OP_MULW:    n_acc = ACC_W'(sat64(r_prod >>> 2, DATA_W));
            OP_LDS:     n_acc = r_s;
            default:    n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exe_en) begin
            r_acc <= n_acc;
            if (op == OP_MOVS) r_s <= r_acc;
        end
        if (we) begin
            case (waddr)
                R_W0:    r_wsh[0] <= wdata;
                R_W1:    r_wsh[1] <= wdata;
                R_W2:    r_wsh[2] <= wdata;
                R_W3:    r_wsh[3] <= wdata;
                R_A00:   r_z00 <= (wdata == '0);
                R_A11:   r_z11 <= (wdata == '0);
                R_B0:    r_c0 <= wdata_in_tol;
                R_B1:    r_c1 <= wdata_in_tol;
                default: ;
            endcase
        end
        if (i_cmd.ok_init) begin
            r_ok <= 1'b1;
        end else if (i_cmd.exe_en && op == OP_CHK && !acc_in_tol) begin
            r_ok <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_weight <= r_wsh;
            o_status <= i_cmd.out_status;
            o_iter   <= i_cmd.out_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.degen     = r_z00 | r_z11;
    assign o_sts.conv      = r_c0 & r_c1;
    assign o_sts.sweep_ok  = r_ok;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_valid = r_out_valid;

endmodule

/* src/ibw_ctrl.sv */
// Controller: microcode sequencer and Newton / Gauss-Seidel loop control.
// Depends on ibw_pkg.
module ibw_ctrl #(
    parameter int ITER_WIDTH = ibw_pkg::DEF_ITER_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_out_ready,
    input  logic [7:0]    i_max_iter,
    input  ibw_pkg::t_sts i_sts,
    output ibw_pkg::t_cmd o_cmd
);
    import ibw_pkg::*;

    localparam logic [16:0] CAP = 17'((1 << ITER_WIDTH) - 1);

    t_state                r_state, n_state;
    t_seg                  r_seg, n_seg;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [3:0]            r_ld, n_ld;
    logic [ITER_WIDTH-1:0] r_used, n_used, r_limit, n_limit, used_inc;
    logic [7:0]            r_sweep, n_sweep, sweep_inc;
    logic                  r_fin, n_fin;
    logic [1:0]            r_status, n_status;
    logic [ITER_WIDTH-1:0] lim_now;
    t_instr                ins;

    assign ins       = ucode(r_pc);
    assign lim_now   = (17'(i_max_iter) > CAP) ? ITER_WIDTH'(CAP) : ITER_WIDTH'(i_max_iter);
    assign used_inc  = r_used + 1'b1;
    assign sweep_inc = r_sweep + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_seg    <= SEG_WGT;
            r_pc     <= PC_WGT;
            r_ld     <= '0;
            r_used   <= '0;
            r_limit  <= '0;
            r_sweep  <= '0;
            r_fin    <= 1'b0;
            r_status <= STAT_LIMIT;
        end else begin
            r_state  <= n_state;
            r_seg    <= n_seg;
            r_pc     <= n_pc;
            r_ld     <= n_ld;
            r_used   <= n_used;
            r_limit  <= n_limit;
            r_sweep  <= n_sweep;
            r_fin    <= n_fin;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_seg    = r_seg;
        n_pc     = r_pc;
        n_ld     = r_ld;
        n_used   = r_used;
        n_limit  = r_limit;
        n_sweep  = r_sweep;
        n_fin    = r_fin;
        n_status = r_status;
        o_ready  = 1'b0;
        o_cmd            = '0;
        o_cmd.ins        = ins;
        o_cmd.load_idx   = r_ld;
        o_cmd.out_status = r_status;
        o_cmd.out_iter   = 8'(r_used);
        case (r_state)
            ST_LOAD: begin
                // operands are copied from the held input one per cycle while i_valid is high
                if (i_valid) begin
                    o_cmd.load_we = 1'b1;
                    if (r_ld == 4'(LOAD_LAST)) begin
                        o_ready  = 1'b1;
                        n_ld     = '0;
                        n_limit  = lim_now;
                        n_used   = '0;
                        n_status = STAT_LIMIT;
                        n_fin    = (lim_now == '0);
                        n_seg    = SEG_WGT;
                        n_pc     = PC_WGT;
                        n_state  = ST_RD;
                    end else begin
                        n_ld = r_ld + 1'b1;
                    end
                end
            end
            ST_RD:  n_state = ST_MUL;
            ST_MUL: n_state = ST_EXE;
            ST_EXE: begin
                o_cmd.exe_en = 1'b1;
                if (ins.op == OP_DIV) begin
                    n_state = ST_DIV;
                end else if (ins.last) begin
                    n_state = ST_NEXT;
                end else begin
                    n_pc    = r_pc + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wb = 1'b1;
                    n_pc         = r_pc + 1'b1;
                    n_state      = ST_RD;
                end
            end
            ST_NEXT: begin
                n_state = ST_RD;
                case (r_seg)
                    SEG_WGT: begin
                        if (r_fin) begin
                            n_state = ST_DONE;
                        end else begin
                            n_seg = SEG_ITER;
                            n_pc  = PC_ITER;
                        end
                    end
                    SEG_ITER: begin
                        if (i_sts.degen) begin
                            n_status = STAT_DEGEN;
                            n_state  = ST_DONE;
                        end else begin
                            n_seg = SEG_GSI;
                            n_pc  = PC_GSI;
                        end
                    end
                    SEG_GSI: begin
                        o_cmd.ok_init = 1'b1;
                        n_sweep       = '0;
                        n_seg         = SEG_SWP;
                        n_pc          = PC_SWP;
                    end
                    SEG_SWP: begin
                        if (i_sts.sweep_ok || sweep_inc == i_max_iter) begin
                            n_seg = SEG_UPD;
                            n_pc  = PC_UPD;
                        end else begin
                            o_cmd.ok_init = 1'b1;
                            n_sweep       = sweep_inc;
                            n_pc          = PC_SWP;
                        end
                    end
                    SEG_UPD: begin
                        n_used = used_inc;
                        if (i_sts.conv) begin
                            n_status = STAT_CONVERGED;
                            n_fin    = 1'b1;
                        end else if (used_inc == r_limit) begin
                            n_fin = 1'b1;
                        end
                        n_seg = SEG_WGT;
                        n_pc  = PC_WGT;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (!i_sts.out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

`ifndef SYNTHESIS
    a_div_wait_on_div_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (ins.op == OP_DIV))
        else $error("divider wait outside a divide instruction");
    a_used_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= r_limit))
        else $error("Newton step count passed its limit");
    a_accept_starts_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_RD && r_pc == PC_WGT && r_used == '0))
        else $error("accepted item did not start at the weight program");
    a_out_load_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_sts.out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

/* src/inverse_bilinear_weights_core.sv */
// Operands are loaded one by one; each microinstruction then passes ST_RD, ST_MUL and
// ST_EXE, a divide waits in ST_DIV, and a Newton step grows with its sweeps, set by the
// single shared multiplier and the bit-serial divider. One item is worked at a time; the
// next is loaded while the previous result waits. Synchronous active-low reset sets
// max_iterations to 50 and tolerance to 1 and empties the result register.
module inverse_bilinear_weights_core #(
    parameter int COORD_WIDTH = ibw_pkg::DEF_COORD_WIDTH,
    parameter int ITER_WIDTH  = ibw_pkg::DEF_ITER_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner0_x,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner1_x,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner2_x,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner3_x,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner0_y,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner1_y,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner2_y,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_corner3_y,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_target_x,
    input  logic signed [ibw_pkg::DATA_W-1:0]   i_target_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ibw_pkg::DATA_W-1:0]   o_weight0,
    output logic signed [ibw_pkg::DATA_W-1:0]   o_weight1,
    output logic signed [ibw_pkg::DATA_W-1:0]   o_weight2,
    output logic signed [ibw_pkg::DATA_W-1:0]   o_weight3,
    output logic [1:0]                          o_status,
    output logic [7:0]                          o_iterations_used,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ibw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ibw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ibw_pkg::*;

    localparam int SAT_W = (COORD_WIDTH < DATA_W) ? COORD_WIDTH : DATA_W;

    logic [7:0]  r_max_iter;
    logic [15:0] r_tol;
    t_cmd        cmd;
    t_sts        sts;
    logic signed [DATA_W-1:0] weights [4];
    logic [NUM_IN-1:0][DATA_W-1:0] load_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RST_MAX_ITER;
            r_tol      <= RST_TOLERANCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_ITER:  r_max_iter <= i_cfg_data[7:0];
                CFG_TOLERANCE: r_tol      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign load_data = {i_target_y, i_target_x,
                        i_corner3_y, i_corner2_y, i_corner1_y, i_corner0_y,
                        i_corner3_x, i_corner2_x, i_corner1_x, i_corner0_x};

    ibw_ctrl #(.ITER_WIDTH(ITER_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .i_max_iter  (r_max_iter),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ibw_datapath #(.SAT_W(SAT_W)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_load_data (load_data),
        .i_tol       (r_tol),
        .i_out_ready (i_ready),
        .o_sts       (sts),
        .o_weight    (weights),
        .o_status    (o_status),
        .o_iter      (o_iterations_used)
    );

    assign o_valid   = sts.out_valid;
    assign o_weight0 = weights[0];
    assign o_weight1 = weights[1];
    assign o_weight2 = weights[2];
    assign o_weight3 = weights[3];

endmodule
